// File: rtl/trilateration_three_anchor_top_assert.svh
// Assertion macros for the trilateration block.
// Depends on nothing; the top level includes it before use.
`ifndef TRILATERATION_THREE_ANCHOR_TOP_ASSERT_SVH
`define TRILATERATION_THREE_ANCHOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define TRI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("trilateration check failed");
`define TRI_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`else
`define TRI_ASSERT(lbl, clk, rst, prop)
`define TRI_ASSERT_MSG(lbl, clk, rst, prop, msg)
`endif
`endif

// File: rtl/trilat_pkg.sv
// Shared types and constants of the trilateration block.
// No dependencies; compile first.
`default_nettype none
package trilat_pkg;
   localparam int FRAC_BITS_DEF = 8;
   localparam int RANGE_W = 16;
   localparam int SQ_W    = 32;
   localparam int NUM_W   = 35;
   localparam int PROD_W  = 52;
   localparam int MAGX_W  = 34;
   localparam int MAGY_W  = 51;
   localparam int QUO_W   = 33;
   localparam int DENX_W  = 18;
   localparam int DENY_W  = 34;
   localparam int POS_W   = 32;
   localparam int Z_W     = 24;

   localparam logic [QUO_W-1:0] POS_LIM = 33'h0_7FFF_FFFF;
   localparam logic [QUO_W-1:0] NEG_LIM = 33'h0_8000_0000;
   localparam logic [Z_W-1:0]   Z_MAX   = 24'hFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CSR_ANCHOR_TWO_X   = 2'd0,
      CSR_ANCHOR_THREE_X = 2'd1,
      CSR_ANCHOR_THREE_Y = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_one;
      logic [RANGE_W-1:0] range_two;
      logic [RANGE_W-1:0] range_three;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [Z_W-1:0]          pos_z;
      logic                    height_invalid;
      logic                    clipped;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/trilat_div_cell.sv
// One restoring division step: one quotient bit at a fixed weight.
// Stand-alone; chained by the top level.
`default_nettype none
module trilat_div_cell #(
   parameter int DEN_BITS = 18,
   parameter int QUO_BITS = 33,
   parameter int SHIFT    = 0
) (
   input  wire logic                         clock,
   input  wire logic                         adv,
   input  wire logic [DEN_BITS+QUO_BITS-1:0] up_rem,
   input  wire logic [DEN_BITS-1:0]          up_den,
   input  wire logic [QUO_BITS-1:0]          up_quo,
   output logic      [DEN_BITS+QUO_BITS-1:0] dn_rem,
   output logic      [DEN_BITS-1:0]          dn_den,
   output logic      [QUO_BITS-1:0]          dn_quo
);
   localparam int REM_W = DEN_BITS + QUO_BITS;

   logic [REM_W-1:0]    den_sh;
   logic                take;
   logic [REM_W-1:0]    rem_in, rem_ff;
   logic [QUO_BITS-1:0] quo_in, quo_ff;
   logic [DEN_BITS-1:0] den_ff;

   always_comb begin
      den_sh = REM_W'(up_den) << SHIFT;
      take   = (up_rem >= den_sh);
      rem_in = take ? (up_rem - den_sh) : up_rem;
      quo_in = up_quo;
      quo_in[SHIFT] = take;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         den_ff <= up_den;
      end
   end

   assign dn_rem = rem_ff;
   assign dn_den = den_ff;
   assign dn_quo = quo_ff;
endmodule
`default_nettype wire

// File: rtl/trilat_sqrt_cell.sv
// One digit-by-digit square root step: one root bit at a fixed weight.
// Stand-alone; chained by the top level.
`default_nettype none
module trilat_sqrt_cell #(
   parameter int RAD_BITS  = 48,
   parameter int ROOT_BITS = 24,
   parameter int SHIFT     = 0
) (
   input  wire logic                 clock,
   input  wire logic                 adv,
   input  wire logic [RAD_BITS-1:0]  up_rem,
   input  wire logic [ROOT_BITS-1:0] up_root,
   output logic      [RAD_BITS-1:0]  dn_rem,
   output logic      [ROOT_BITS-1:0] dn_root
);
   logic [RAD_BITS:0]    trial;
   logic                 take;
   logic [RAD_BITS-1:0]  rem_in, rem_ff;
   logic [ROOT_BITS-1:0] root_in, root_ff;

   // (R + 2^k)^2 - R^2 = R * 2^(k+1) + 2^(2k)
   always_comb begin
      trial   = ((RAD_BITS+1)'(up_root) << (SHIFT + 1)) + ((RAD_BITS+1)'(1) << (2 * SHIFT));
      take    = ({1'b0, up_rem} >= trial);
      rem_in  = take ? (up_rem - trial[RAD_BITS-1:0]) : up_rem;
      root_in = up_root;
      root_in[SHIFT] = take;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
endmodule
`default_nettype wire

// File: rtl/trilateration_three_anchor_top.sv
// Three-anchor trilateration pipeline: front arithmetic, divider and root cell rows.
// Depends on trilat_pkg, trilat_div_cell, trilat_sqrt_cell and the assert header.
//
//   channel  dir  handshake              beat
//   req      in   req_valid/req_ready    req_data (three ranges)
//   rsp      out  rsp_valid/rsp_ready    rsp_data (x, y, z, flags)
//   csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// One beat enters per cycle unless the pipeline is frozen; the path runs through the two rows
// of 33 divider cells and the row of 16 + FRAC_BITS root cells.
// Reset is synchronous; it clears valid bits and loads 100 into the three anchors.
// A stalled rsp fills a one-entry skid; only a full skid freezes the pipeline.
// csr writes are always taken; a write during reset is lost.
`default_nettype none
`include "trilateration_three_anchor_top_assert.svh"
module trilateration_three_anchor_top
   import trilat_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [RANGE_W-1:0] csr_wdata
);
   localparam int REMX_W  = DENX_W + QUO_W;
   localparam int REMY_W  = DENY_W + QUO_W;
   localparam int NXA_W   = MAGX_W + FRAC_BITS + 2;
   localparam int NYA_W   = MAGY_W + FRAC_BITS + 2;
   localparam int NXF_W   = ((NXA_W > REMX_W) ? NXA_W : REMX_W) + 1;
   localparam int NYF_W   = ((NYA_W > REMY_W) ? NYA_W : REMY_W) + 1;
   localparam int CMP_W   = 2 * POS_W;
   localparam int RAD_W   = SQ_W + 2 * FRAC_BITS;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int ZC_W    = (ROOT_W > Z_W) ? ROOT_W : Z_W;
   localparam int FRONT_N = 7;
   localparam int POST_N  = 4;
   localparam int LAST_D  = QUO_W - 1;
   localparam int LAST_S  = ROOT_W - 1;

   // sideband that rides beside the divider row
   typedef struct packed {
      logic            neg_x;
      logic            neg_y;
      logic            ovf_x;
      logic            ovf_y;
      logic [SQ_W-1:0] r1sq;
   } dsb_type;

   // sideband that rides beside the root row
   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic                    sat;
      logic                    bad;
   } ssb_type;

   // ---------------- configuration ----------------
   logic [RANGE_W-1:0]        a2x_ff;
   logic signed [RANGE_W-1:0] a3x_ff;
   logic [RANGE_W-1:0]        a3y_ff;
   logic [RANGE_W-1:0]        d_eff, j_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a2x_ff <= RANGE_W'(100);
         a3x_ff <= RANGE_W'(100);
         a3y_ff <= RANGE_W'(100);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ANCHOR_TWO_X:   a2x_ff <= csr_wdata;
            CSR_ANCHOR_THREE_X: a3x_ff <= csr_wdata;
            CSR_ANCHOR_THREE_Y: a3y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   // a zero anchor-two x or anchor-three y acts as one
   assign d_eff = (a2x_ff == '0) ? RANGE_W'(1) : a2x_ff;
   assign j_eff = (a3y_ff == '0) ? RANGE_W'(1) : a3y_ff;

   // ---------------- flow control ----------------
   logic adv;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in, out_ff, out_in, new_data;

   // advance the whole pipeline unless the skid holds a beat
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   logic [FRONT_N-1:0] vfr_ff;
   logic [QUO_W-1:0]   vdiv_ff;
   logic [POST_N-1:0]  vpost_ff;
   logic [ROOT_W-1:0]  vsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vfr_ff   <= '0;
         vdiv_ff  <= '0;
         vpost_ff <= '0;
         vsq_ff   <= '0;
      end else if (adv) begin
         vfr_ff   <= {vfr_ff[FRONT_N-2:0], req_valid};
         vdiv_ff  <= {vdiv_ff[QUO_W-2:0], vfr_ff[FRONT_N-1]};
         vpost_ff <= {vpost_ff[POST_N-2:0], vdiv_ff[LAST_D]};
         vsq_ff   <= {vsq_ff[ROOT_W-2:0], vpost_ff[POST_N-1]};
      end
   end

   // ---------------- front stages ----------------
   req_type ra_ff;
   // squares and the anchor product
   logic [SQ_W-1:0] r1sq_b_ff, r2sq_b_ff, r3sq_b_ff, dsq_b_ff, isq_b_ff, jsq_b_ff, jd_b_ff;
   logic signed [SQ_W-1:0] isq_s;
   logic [RANGE_W-1:0] d_b_ff;
   logic signed [RANGE_W-1:0] i_b_ff;
   // numerators
   logic signed [NUM_W-1:0] nx_c_in, ny_c_in, nx_c_ff, ny_c_ff;
   logic [SQ_W-1:0] r1sq_c_ff, jd_c_ff;
   logic [RANGE_W-1:0] d_c_ff;
   logic signed [RANGE_W-1:0] i_c_ff;
   // cross products
   logic signed [PROD_W-1:0] nyd_d_in, inx_d_in, nyd_d_ff, inx_d_ff;
   logic signed [NUM_W-1:0] nx_d_ff;
   logic [SQ_W-1:0] r1sq_d_ff, jd_d_ff;
   logic [RANGE_W-1:0] d_d_ff;
   // y numerator, x magnitude
   logic signed [PROD_W-1:0] nxy_e_ff;
   logic [MAGX_W-1:0] magx_e_in, magx_e_ff;
   logic negx_e_ff;
   logic [SQ_W-1:0] r1sq_e_ff, jd_e_ff;
   logic [RANGE_W-1:0] d_e_ff;
   // y magnitude
   logic [MAGY_W-1:0] magy_f_in, magy_f_ff, magx_f_ff;
   logic negy_f_ff, negx_f_ff;
   logic [SQ_W-1:0] r1sq_f_ff, jd_f_ff;
   logic [RANGE_W-1:0] d_f_ff;
   // divider operands
   logic [NXF_W-1:0] nxf;
   logic [NYF_W-1:0] nyf;
   logic [DENX_W-1:0] dx;
   logic [DENY_W-1:0] dy;
   logic [REMX_W-1:0] xrem_g_ff;
   logic [REMY_W-1:0] yrem_g_ff;
   logic [DENX_W-1:0] xden_g_ff;
   logic [DENY_W-1:0] yden_g_ff;
   dsb_type dsb_g_ff, dsb_g_in;

   assign isq_s = a3x_ff * a3x_ff;

   always_comb begin
      nx_c_in = $signed(NUM_W'(r1sq_b_ff)) - $signed(NUM_W'(r2sq_b_ff))
              + $signed(NUM_W'(dsq_b_ff));
      ny_c_in = $signed(NUM_W'(r1sq_b_ff)) - $signed(NUM_W'(r3sq_b_ff))
              + $signed(NUM_W'(isq_b_ff)) + $signed(NUM_W'(jsq_b_ff));
      nyd_d_in = ny_c_ff * $signed({1'b0, d_c_ff});
      inx_d_in = i_c_ff * nx_c_ff;
      magx_e_in = nx_d_ff[NUM_W-1] ? MAGX_W'(-nx_d_ff) : MAGX_W'(nx_d_ff);
      magy_f_in = nxy_e_ff[PROD_W-1] ? MAGY_W'(-nxy_e_ff) : MAGY_W'(nxy_e_ff);
      // N = mag * 2^(F+1) + den and D = 2 * den, so N / D rounds half up
      dx  = {d_f_ff, 2'b00};
      dy  = {jd_f_ff, 2'b00};
      nxf = (NXF_W'(magx_f_ff) << (FRAC_BITS + 1)) + NXF_W'({d_f_ff, 1'b0});
      nyf = (NYF_W'(magy_f_ff) << (FRAC_BITS + 1)) + NYF_W'({jd_f_ff, 1'b0});
      dsb_g_in.neg_x = negx_f_ff;
      dsb_g_in.neg_y = negy_f_ff;
      dsb_g_in.ovf_x = (nxf >= (NXF_W'(dx) << QUO_W));
      dsb_g_in.ovf_y = (nyf >= (NYF_W'(dy) << QUO_W));
      dsb_g_in.r1sq  = r1sq_f_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_ff     <= req_data;
         r1sq_b_ff <= SQ_W'(ra_ff.range_one) * SQ_W'(ra_ff.range_one);
         r2sq_b_ff <= SQ_W'(ra_ff.range_two) * SQ_W'(ra_ff.range_two);
         r3sq_b_ff <= SQ_W'(ra_ff.range_three) * SQ_W'(ra_ff.range_three);
         dsq_b_ff  <= SQ_W'(d_eff) * SQ_W'(d_eff);
         jsq_b_ff  <= SQ_W'(j_eff) * SQ_W'(j_eff);
         isq_b_ff  <= isq_s;
         jd_b_ff   <= SQ_W'(d_eff) * SQ_W'(j_eff);
         d_b_ff    <= d_eff;
         i_b_ff    <= a3x_ff;

         nx_c_ff   <= nx_c_in;
         ny_c_ff   <= ny_c_in;
         r1sq_c_ff <= r1sq_b_ff;
         jd_c_ff   <= jd_b_ff;
         d_c_ff    <= d_b_ff;
         i_c_ff    <= i_b_ff;

         nyd_d_ff  <= nyd_d_in;
         inx_d_ff  <= inx_d_in;
         nx_d_ff   <= nx_c_ff;
         r1sq_d_ff <= r1sq_c_ff;
         jd_d_ff   <= jd_c_ff;
         d_d_ff    <= d_c_ff;

         nxy_e_ff  <= nyd_d_ff - inx_d_ff;
         magx_e_ff <= magx_e_in;
         negx_e_ff <= nx_d_ff[NUM_W-1];
         r1sq_e_ff <= r1sq_d_ff;
         jd_e_ff   <= jd_d_ff;
         d_e_ff    <= d_d_ff;

         magy_f_ff <= magy_f_in;
         negy_f_ff <= nxy_e_ff[PROD_W-1];
         magx_f_ff <= MAGY_W'(magx_e_ff);
         negx_f_ff <= negx_e_ff;
         r1sq_f_ff <= r1sq_e_ff;
         jd_f_ff   <= jd_e_ff;
         d_f_ff    <= d_e_ff;

         xrem_g_ff <= nxf[REMX_W-1:0];
         yrem_g_ff <= nyf[REMY_W-1:0];
         xden_g_ff <= dx;
         yden_g_ff <= dy;
         dsb_g_ff  <= dsb_g_in;
      end
   end

   // ---------------- divider rows ----------------
   logic [REMX_W-1:0] xrem_up [QUO_W];
   logic [REMX_W-1:0] xrem_dn [QUO_W];
   logic [DENX_W-1:0] xden_up [QUO_W];
   logic [DENX_W-1:0] xden_dn [QUO_W];
   logic [QUO_W-1:0]  xquo_up [QUO_W];
   logic [QUO_W-1:0]  xquo_dn [QUO_W];
   logic [REMY_W-1:0] yrem_up [QUO_W];
   logic [REMY_W-1:0] yrem_dn [QUO_W];
   logic [DENY_W-1:0] yden_up [QUO_W];
   logic [DENY_W-1:0] yden_dn [QUO_W];
   logic [QUO_W-1:0]  yquo_up [QUO_W];
   logic [QUO_W-1:0]  yquo_dn [QUO_W];
   dsb_type dsb_ff [QUO_W];

   for (genvar c = 0; c < QUO_W; c++) begin : g_div
      if (c == 0) begin : g_head
         assign xrem_up[c] = xrem_g_ff;
         assign xden_up[c] = xden_g_ff;
         assign xquo_up[c] = '0;
         assign yrem_up[c] = yrem_g_ff;
         assign yden_up[c] = yden_g_ff;
         assign yquo_up[c] = '0;
         always_ff @(posedge clock) begin
            if (adv) begin
               dsb_ff[c] <= dsb_g_ff;
            end
         end
      end else begin : g_link
         assign xrem_up[c] = xrem_dn[c-1];
         assign xden_up[c] = xden_dn[c-1];
         assign xquo_up[c] = xquo_dn[c-1];
         assign yrem_up[c] = yrem_dn[c-1];
         assign yden_up[c] = yden_dn[c-1];
         assign yquo_up[c] = yquo_dn[c-1];
         always_ff @(posedge clock) begin
            if (adv) begin
               dsb_ff[c] <= dsb_ff[c-1];
            end
         end
      end

      trilat_div_cell #(
         .DEN_BITS(DENX_W), .QUO_BITS(QUO_W), .SHIFT(QUO_W - 1 - c)
      ) u_xcell (
         .clock(clock), .adv(adv),
         .up_rem(xrem_up[c]), .up_den(xden_up[c]), .up_quo(xquo_up[c]),
         .dn_rem(xrem_dn[c]), .dn_den(xden_dn[c]), .dn_quo(xquo_dn[c])
      );

      trilat_div_cell #(
         .DEN_BITS(DENY_W), .QUO_BITS(QUO_W), .SHIFT(QUO_W - 1 - c)
      ) u_ycell (
         .clock(clock), .adv(adv),
         .up_rem(yrem_up[c]), .up_den(yden_up[c]), .up_quo(yquo_up[c]),
         .dn_rem(yrem_dn[c]), .dn_den(yden_dn[c]), .dn_quo(yquo_dn[c])
      );
   end

   // ---------------- saturation, squares, radicand ----------------
   logic [QUO_W-1:0] limx, limy, valx, valy;
   logic satx, saty;
   ssb_type ph_in, ph_ff, pi_ff, pj_ff, pk_ff;
   logic [POS_W-1:0] ax_h_ff, ay_h_ff;
   logic [SQ_W-1:0]  r1sq_h_ff;
   logic [CMP_W-1:0] axsq_i_ff, aysq_i_ff, a_i_ff, s_j_ff, a_j_ff;
   logic [RAD_W-1:0] rad_k_ff;

   always_comb begin
      limx = dsb_ff[LAST_D].neg_x ? NEG_LIM : POS_LIM;
      limy = dsb_ff[LAST_D].neg_y ? NEG_LIM : POS_LIM;
      satx = dsb_ff[LAST_D].ovf_x || (xquo_dn[LAST_D] > limx);
      saty = dsb_ff[LAST_D].ovf_y || (yquo_dn[LAST_D] > limy);
      valx = satx ? limx : xquo_dn[LAST_D];
      valy = saty ? limy : yquo_dn[LAST_D];
      ph_in.px  = dsb_ff[LAST_D].neg_x ? POS_W'(-valx) : POS_W'(valx);
      ph_in.py  = dsb_ff[LAST_D].neg_y ? POS_W'(-valy) : POS_W'(valy);
      ph_in.sat = satx || saty;
      ph_in.bad = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff     <= ph_in;
         ax_h_ff   <= valx[POS_W-1:0];
         ay_h_ff   <= valy[POS_W-1:0];
         r1sq_h_ff <= dsb_ff[LAST_D].r1sq;

         axsq_i_ff <= CMP_W'(ax_h_ff) * CMP_W'(ax_h_ff);
         aysq_i_ff <= CMP_W'(ay_h_ff) * CMP_W'(ay_h_ff);
         a_i_ff    <= CMP_W'(r1sq_h_ff) << (2 * FRAC_BITS);
         pi_ff     <= ph_ff;

         s_j_ff    <= axsq_i_ff + aysq_i_ff;
         a_j_ff    <= a_i_ff;
         pj_ff     <= pi_ff;

         // negative radicand: flag it, the root row result is dropped
         rad_k_ff  <= RAD_W'(a_j_ff - s_j_ff);
         pk_ff.px  <= pj_ff.px;
         pk_ff.py  <= pj_ff.py;
         pk_ff.sat <= pj_ff.sat;
         pk_ff.bad <= (a_j_ff < s_j_ff);
      end
   end

   // ---------------- root row ----------------
   logic [RAD_W-1:0]  srem_up  [ROOT_W];
   logic [RAD_W-1:0]  srem_dn  [ROOT_W];
   logic [ROOT_W-1:0] sroot_up [ROOT_W];
   logic [ROOT_W-1:0] sroot_dn [ROOT_W];
   ssb_type ssb_ff [ROOT_W];

   for (genvar c = 0; c < ROOT_W; c++) begin : g_sqrt
      if (c == 0) begin : g_head
         assign srem_up[c]  = rad_k_ff;
         assign sroot_up[c] = '0;
         always_ff @(posedge clock) begin
            if (adv) begin
               ssb_ff[c] <= pk_ff;
            end
         end
      end else begin : g_link
         assign srem_up[c]  = srem_dn[c-1];
         assign sroot_up[c] = sroot_dn[c-1];
         always_ff @(posedge clock) begin
            if (adv) begin
               ssb_ff[c] <= ssb_ff[c-1];
            end
         end
      end

      trilat_sqrt_cell #(
         .RAD_BITS(RAD_W), .ROOT_BITS(ROOT_W), .SHIFT(ROOT_W - 1 - c)
      ) u_scell (
         .clock(clock), .adv(adv),
         .up_rem(srem_up[c]), .up_root(sroot_up[c]),
         .dn_rem(srem_dn[c]), .dn_root(sroot_dn[c])
      );
   end

   // ---------------- result register and skid ----------------
   logic [ZC_W-1:0] zc;

   always_comb begin
      zc = ZC_W'(sroot_dn[LAST_S]);
      new_data.pos_x          = ssb_ff[LAST_S].px;
      new_data.pos_y          = ssb_ff[LAST_S].py;
      new_data.clipped        = ssb_ff[LAST_S].sat;
      new_data.height_invalid = ssb_ff[LAST_S].bad;
      if (ssb_ff[LAST_S].bad) begin
         new_data.pos_z = '0;
      end else if (zc > ZC_W'(Z_MAX)) begin
         new_data.pos_z = Z_MAX;
      end else begin
         new_data.pos_z = zc[Z_W-1:0];
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (adv) begin
         if (out_valid_ff && !rsp_ready) begin
            // result register blocked: park the arriving beat in the skid
            if (vsq_ff[LAST_S]) begin
               skid_in       = new_data;
               skid_valid_in = 1'b1;
            end
         end else begin
            out_in       = new_data;
            out_valid_in = vsq_ff[LAST_S];
         end
      end else if (rsp_ready) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ---------------- checks ----------------
`TRI_ASSERT(a_skid_needs_out, clock, reset, skid_valid_ff |-> out_valid_ff)
`TRI_ASSERT(a_z_zero_when_invalid, clock, reset, rsp_valid && rsp_data.height_invalid |-> rsp_data.pos_z == '0)
`TRI_ASSERT_MSG(a_clip_at_limit, clock, reset, rsp_valid && rsp_data.clipped |-> (rsp_data.pos_x == POS_MAX || rsp_data.pos_x == POS_MIN || rsp_data.pos_y == POS_MAX || rsp_data.pos_y == POS_MIN), "clipped beat without a saturated coordinate")
`TRI_ASSERT_MSG(a_div_rem_x, clock, reset, vdiv_ff[LAST_D] && !dsb_ff[LAST_D].ovf_x |-> xrem_dn[LAST_D] < REMX_W'(xden_dn[LAST_D]), "x divider remainder not below divisor")
`TRI_ASSERT_MSG(a_div_rem_y, clock, reset, vdiv_ff[LAST_D] && !dsb_ff[LAST_D].ovf_y |-> yrem_dn[LAST_D] < REMY_W'(yden_dn[LAST_D]), "y divider remainder not below divisor")
endmodule
`default_nettype wire
